@@ sv/mono_synth_voice_top_assert.svh @@
// ----------------------------------------------------------------------------
// Mono synth voice assertion macros
// Shared property forms used by the voice top level.
// ----------------------------------------------------------------------------
`ifndef MONO_SYNTH_VOICE_TOP_ASSERT_SVH
`define MONO_SYNTH_VOICE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MSV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voice assertion failed");

// Next-cycle implication, checked out of reset.
`define MSV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voice assertion failed");

`endif

@@ sv/msv_pkg.sv @@
// ----------------------------------------------------------------------------
// Mono synth voice package
// Types, constants and elaboration-time table builders for the voice.
// ----------------------------------------------------------------------------
`default_nettype none

package msv_pkg;

  localparam int unsigned SAMPLE_RATE    = 48000;
  localparam int unsigned ATTACK_SAMPLES = 480;
  localparam int unsigned DECAY_SAMPLES  = 4800;
  localparam int unsigned SINE_ENTRIES   = 1024;
  localparam int unsigned SINE_BITS      = $clog2(SINE_ENTRIES);
  localparam int unsigned SINE_QBITS     = SINE_BITS - 2;
  localparam int unsigned SINE_QSTEPS    = 1 << SINE_QBITS;

  localparam int unsigned MSV_QUEUE_DEPTH = 4;
  localparam int unsigned IN_TDATA_W      = 48;
  localparam int unsigned OUT_TDATA_W     = 24;
  localparam int unsigned NOTE_COUNT      = 128;

  localparam logic [63:0] PEAK_SCALE  = 64'd45875;
  localparam logic [15:0] GAIN_FLOOR  = 16'd7;
  localparam logic [6:0]  CC_GLIDE    = 7'd74;
  localparam logic [14:0] NORM_SINE   = 15'd16384;
  localparam logic [14:0] NORM_SAW    = 15'd20070;
  localparam logic [14:0] NORM_SQUARE = 15'd11583;
  localparam logic [63:0] TWO_PI_Q28  = 64'd1686629713;
  localparam logic [63:0] VEL_CUBE    = 64'd2048383;

  localparam logic [1:0]  WAVE_RESET       = 2'd0;
  localparam logic [15:0] GLIDE_INIT_RESET = 16'd65263;
  localparam logic [15:0] SUSTAIN_RESET    = 16'd45875;
  localparam logic [15:0] RELEASE_RESET    = 16'd65531;

  localparam logic [1:0] WAVE_SAW    = 2'd1;
  localparam logic [1:0] WAVE_SQUARE = 2'd2;

  localparam logic [1:0] CFG_WAVEFORM   = 2'd0;
  localparam logic [1:0] CFG_GLIDE_INIT = 2'd1;
  localparam logic [1:0] CFG_SUSTAIN    = 2'd2;
  localparam logic [1:0] CFG_RELEASE    = 2'd3;

  // Reciprocals for divide-by-constant, 2^32 / D.
  localparam logic [32:0] ATT_RECIP = 33'((64'd1 << 32) / ATTACK_SAMPLES);
  localparam logic [32:0] DEC_RECIP = 33'((64'd1 << 32) / DECAY_SAMPLES);

  localparam logic [31:0] TOP_OCTAVE [12] = '{
    32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
    32'd691279090, 32'd732384684, 32'd775934544, 32'd822074012,
    32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
  };

  typedef enum logic [1:0] {
    FUNC_NOTE_ON  = 2'd0,
    FUNC_NOTE_OFF = 2'd1,
    FUNC_CC       = 2'd2,
    FUNC_TICK     = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ENV_IDLE    = 3'd0,
    ENV_ATTACK  = 3'd1,
    ENV_DECAY   = 3'd2,
    ENV_SUSTAIN = 3'd3,
    ENV_RELEASE = 3'd4
  } env_phase_t;

  typedef enum logic [3:0] {
    ST_FETCH,
    ST_ATT_DIV,
    ST_ATT_FIX,
    ST_DEC_SCALE,
    ST_DEC_DIV,
    ST_DEC_FIX,
    ST_GAIN_LOAD,
    ST_REL,
    ST_GLIDE,
    ST_WAVE,
    ST_VOICE,
    ST_NORM,
    ST_MIX,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    func_t              kind;
    logic [31:0]        inc;
    logic [15:0]        peak;
    logic [15:0]        coeff;
    logic signed [15:0] mix;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] a);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] b;
    rem = a;
    r   = 64'd0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] peak_of(input logic [6:0] v);
    logic [63:0] c;
    logic [63:0] s;
    logic [63:0] p;
    c = 64'(v) * 64'(v) * 64'(v);
    s = isqrt64((c << 32) / VEL_CUBE);
    p = (s * PEAK_SCALE + 64'd32768) >> 16;
    return p[15:0];
  endfunction

  function automatic logic [15:0] glide_of_x(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] x3;
    logic [63:0] e;
    logic [63:0] q;
    x2 = (x * x) >> 32;
    x3 = (x2 * x) >> 32;
    e  = (64'd1 << 32) - x + (x2 >> 1) - x3 / 64'd6;
    q  = (e + 64'd32768) >> 16;
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  // Sine of a quarter-turn angle (Q0.32 turn), result Q1.15 magnitude.
  function automatic logic [15:0] quarter_sine(input logic [63:0] x);
    logic [63:0] one;
    logic [63:0] th;
    logic [63:0] t2;
    logic [63:0] r;
    logic [63:0] s;
    one = 64'd1 << 30;
    th  = (x * TWO_PI_Q28) >> 30;
    t2  = (th * th) >> 30;
    r   = one;
    r   = one - ((t2 * r) >> 30) / 64'd110;
    r   = one - ((t2 * r) >> 30) / 64'd72;
    r   = one - ((t2 * r) >> 30) / 64'd42;
    r   = one - ((t2 * r) >> 30) / 64'd20;
    r   = one - ((t2 * r) >> 30) / 64'd6;
    s   = (((th * r) >> 30) + 64'd16384) >> 15;
    return s[15:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/msv_front.sv @@
// ----------------------------------------------------------------------------
// Mono synth voice front end
// Accepts input words, decodes the kind and looks up pitch, peak and glide.
// ----------------------------------------------------------------------------
`default_nettype none

module msv_front import msv_pkg::*; (
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // note[6:0], velocity[13:7], cc_number[20:14], cc_value[27:21],
  // mix_in[43:28], zero fill
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]            s_axis_tuser,
  input  wire q_stat_t               q_stat,
  output logic                       push,
  output cmd_t                       push_cmd
);

  logic [31:0] inc_tab   [NOTE_COUNT];
  logic [15:0] peak_tab  [NOTE_COUNT];
  logic [15:0] glide_tab [NOTE_COUNT];

  for (genvar n = 0; n < NOTE_COUNT; n++) begin : g_tab
    localparam int unsigned OCT  = n / 12;
    localparam int unsigned SEMI = n % 12;
    localparam logic [63:0] DEN  = 64'(SAMPLE_RATE) << (10 - OCT);
    localparam logic [63:0] RAW  = ((64'(TOP_OCTAVE[SEMI]) << 16) + (DEN >> 1)) / DEN;
    localparam logic [63:0] GX   =
      (64'd127000 << 32) / (64'(SAMPLE_RATE) * (64'd635 + 64'd395 * 64'(n)));
    assign inc_tab[n]   = (RAW > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : RAW[31:0];
    assign peak_tab[n]  = peak_of(7'(n));
    assign glide_tab[n] = glide_of_x(GX);
  end

  func_t       func;
  logic [6:0]  note;
  logic [6:0]  velocity;
  logic [6:0]  cc_number;
  logic [6:0]  cc_value;

  assign func      = func_t'(s_axis_tuser);
  assign note      = s_axis_tdata[6:0];
  assign velocity  = s_axis_tdata[13:7];
  assign cc_number = s_axis_tdata[20:14];
  assign cc_value  = s_axis_tdata[27:21];

  assign s_axis_tready = !q_stat.full;

  // Drop controllers other than the glide one here.
  assign push = s_axis_tvalid && !q_stat.full
             && ((func != FUNC_CC) || (cc_number == CC_GLIDE));

  always_comb begin
    push_cmd.kind  = func;
    push_cmd.inc   = inc_tab[note];
    push_cmd.peak  = peak_tab[velocity];
    push_cmd.coeff = glide_tab[cc_value];
    push_cmd.mix   = $signed(s_axis_tdata[43:28]);
  end

endmodule

`default_nettype wire

@@ sv/msv_queue.sv @@
// ----------------------------------------------------------------------------
// Mono synth voice command queue
// Short FIFO of decoded commands between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module msv_queue import msv_pkg::*; #(
  parameter int unsigned DEPTH = MSV_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output q_stat_t   q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = mem[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/msv_back.sv @@
// ----------------------------------------------------------------------------
// Mono synth voice back end
// Runs note events and sample ticks through one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module msv_back import msv_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [15:0]            cfg_data,
  input  wire q_stat_t                q_stat,
  input  wire cmd_t                   head,
  output logic                        pop,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // sample_out[15:0], env_state[18:16], zero fill
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  back_state_t state;
  back_state_t state_next;

  logic [1:0]  waveform;
  logic [15:0] sustain_level;
  logic [15:0] release_coeff;

  env_phase_t  env_phase;
  logic [15:0] env_count;
  logic [15:0] gain;
  logic [15:0] target_peak;
  logic [31:0] phase_acc;
  logic [31:0] current_inc;
  logic [31:0] target_inc;
  logic [15:0] glide_coeff;
  logic        cc_seen;

  logic [65:0]        prod;
  logic [32:0]        mul_a;
  logic [32:0]        mul_b;
  logic [31:0]        div_num;
  logic signed [15:0] mix;
  logic [16:0]        wave_mag;
  logic               wave_neg;
  logic [15:0]        res_sample;
  env_phase_t         res_env;

  logic [15:0] sine_tab [SINE_QSTEPS + 1];

  for (genvar i = 0; i <= SINE_QSTEPS; i++) begin : g_sine
    assign sine_tab[i] = quarter_sine(64'(i) << (32 - SINE_BITS));
  end

  assign cfg_ready = 1'b1;

  // Divide-by-constant corrections and envelope counter.
  logic [31:0] q0;
  logic [31:0] att_rem;
  logic [31:0] att_q;
  logic [31:0] dec_rem;
  logic [31:0] dec_q;
  logic [15:0] count_inc;
  logic        glide_up;
  logic [31:0] glide_d;

  assign q0        = prod[63:32];
  assign att_rem   = div_num - 32'(q0 * 32'(ATTACK_SAMPLES));
  assign att_q     = q0 + 32'(att_rem >= 32'(ATTACK_SAMPLES));
  assign dec_rem   = div_num - 32'(q0 * 32'(DECAY_SAMPLES));
  assign dec_q     = q0 + 32'(dec_rem >= 32'(DECAY_SAMPLES));
  assign count_inc = env_count + 16'd1;
  assign glide_up  = (current_inc >= target_inc);
  assign glide_d   = glide_up ? (current_inc - target_inc) : (target_inc - current_inc);

  // Wave shape from the advanced phase.
  logic [SINE_BITS-1:0]  sidx;
  logic [1:0]            quad;
  logic [SINE_QBITS-1:0] sfrac;
  logic [SINE_QBITS:0]   sx;
  logic [16:0]           wave_mag_next;
  logic                  wave_neg_next;

  assign sidx  = phase_acc[31 -: SINE_BITS];
  assign quad  = sidx[SINE_BITS-1 -: 2];
  assign sfrac = sidx[SINE_QBITS-1:0];
  assign sx    = quad[0] ? ((SINE_QBITS + 1)'(SINE_QSTEPS) - {1'b0, sfrac}) : {1'b0, sfrac};

  always_comb begin
    case (waveform)
      WAVE_SAW: begin
        wave_neg_next = !phase_acc[31];
        wave_mag_next = phase_acc[31] ? {2'b00, phase_acc[30:16]}
                                      : 17'd32768 - {2'b00, phase_acc[30:16]};
      end
      WAVE_SQUARE: begin
        wave_neg_next = phase_acc[31];
        wave_mag_next = 17'd32768;
      end
      default: begin
        wave_neg_next = quad[1];
        wave_mag_next = {1'b0, sine_tab[sx]};
      end
    endcase
  end

  logic [14:0] norm;

  always_comb begin
    case (waveform)
      WAVE_SAW:    norm = NORM_SAW;
      WAVE_SQUARE: norm = NORM_SQUARE;
      default:     norm = NORM_SINE;
    endcase
  end

  // Round, sign and saturate the voice onto the mix sample.
  logic [47:0]        voice_rnd;
  logic [17:0]        voice_mag;
  logic signed [18:0] mix_sum;
  logic [15:0]        mix_sat;

  assign voice_rnd = prod[47:0] + 48'(1 << 29);
  assign voice_mag = voice_rnd[47:30];
  assign mix_sum   = wave_neg ? (19'(mix) - $signed({1'b0, voice_mag}))
                              : (19'(mix) + $signed({1'b0, voice_mag}));

  always_comb begin
    if (mix_sum > 19'sd32767) begin
      mix_sat = 16'h7FFF;
    end else if (mix_sum < -19'sd32768) begin
      mix_sat = 16'h8000;
    end else begin
      mix_sat = mix_sum[15:0];
    end
  end

  logic fetch_tick;
  logic emit_ok;

  assign fetch_tick = !q_stat.empty && (head.kind == FUNC_TICK);
  assign emit_ok    = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_FETCH: begin
        if (fetch_tick) begin
          unique case (env_phase)
            ENV_ATTACK:  state_next = ST_ATT_DIV;
            ENV_DECAY:   state_next = ST_DEC_SCALE;
            ENV_SUSTAIN: state_next = ST_GLIDE;
            ENV_RELEASE: state_next = ST_REL;
            default:     state_next = ST_EMIT;
          endcase
        end
      end
      ST_ATT_DIV:   state_next = ST_ATT_FIX;
      ST_ATT_FIX:   state_next = ST_GLIDE;
      ST_DEC_SCALE: state_next = ST_DEC_DIV;
      ST_DEC_DIV:   state_next = ST_DEC_FIX;
      ST_DEC_FIX:   state_next = (count_inc >= 16'(DECAY_SAMPLES)) ? ST_GAIN_LOAD : ST_GLIDE;
      ST_GAIN_LOAD: state_next = ST_GLIDE;
      ST_REL:       state_next = (prod[31:16] < GAIN_FLOOR) ? ST_EMIT : ST_GLIDE;
      ST_GLIDE:     state_next = ST_WAVE;
      ST_WAVE:      state_next = ST_VOICE;
      ST_VOICE:     state_next = ST_NORM;
      ST_NORM:      state_next = ST_MIX;
      ST_MIX:       state_next = ST_EMIT;
      ST_EMIT:      state_next = emit_ok ? ST_FETCH : ST_EMIT;
      default:      state_next = ST_FETCH;
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_FETCH: begin
        pop = !q_stat.empty;
        if (env_phase == ENV_RELEASE) begin
          mul_a = {17'd0, gain};
          mul_b = {17'd0, release_coeff};
        end else begin
          mul_a = {17'd0, env_count};
          mul_b = {17'd0, target_peak};
        end
      end
      ST_ATT_DIV: begin
        mul_a = {1'b0, prod[31:0]};
        mul_b = ATT_RECIP;
      end
      ST_DEC_SCALE: begin
        mul_a = {1'b0, prod[31:0]};
        mul_b = 33'(17'h10000 - {1'b0, sustain_level});
      end
      ST_DEC_DIV: begin
        mul_a = {1'b0, prod[47:16]};
        mul_b = DEC_RECIP;
      end
      ST_DEC_FIX: begin
        mul_a = {17'd0, target_peak};
        mul_b = {17'd0, sustain_level};
      end
      ST_GLIDE: begin
        mul_a = {1'b0, glide_d};
        mul_b = {17'd0, glide_coeff};
      end
      ST_VOICE: begin
        mul_a = {17'd0, gain};
        mul_b = {16'd0, wave_mag};
      end
      ST_NORM: begin
        mul_a = prod[32:0];
        mul_b = {18'd0, norm};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_FETCH;
      waveform         <= WAVE_RESET;
      sustain_level    <= SUSTAIN_RESET;
      release_coeff    <= RELEASE_RESET;
      env_phase        <= ENV_IDLE;
      env_count        <= '0;
      gain             <= '0;
      target_peak      <= '0;
      phase_acc        <= '0;
      current_inc      <= '0;
      target_inc       <= '0;
      glide_coeff      <= GLIDE_INIT_RESET;
      cc_seen          <= 1'b0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_WAVEFORM: waveform <= cfg_data[1:0];
          CFG_GLIDE_INIT: begin
            if (!cc_seen) begin
              glide_coeff <= cfg_data;
            end
          end
          CFG_SUSTAIN: sustain_level <= cfg_data;
          CFG_RELEASE: release_coeff <= cfg_data;
          default: ;
        endcase
      end

      // Raise valid when a result is ready, drop it once the word is taken.
      if (state == ST_EMIT && emit_ok) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_FETCH: begin
          if (!q_stat.empty) begin
            case (head.kind)
              FUNC_NOTE_ON: begin
                target_inc <= head.inc;
                if (env_phase == ENV_IDLE) begin
                  current_inc <= head.inc;
                  phase_acc   <= '0;
                end
                if (env_phase == ENV_IDLE || env_phase == ENV_RELEASE) begin
                  env_phase   <= ENV_ATTACK;
                  env_count   <= '0;
                  target_peak <= head.peak;
                  gain        <= '0;
                end
              end
              FUNC_NOTE_OFF: begin
                if (env_phase != ENV_IDLE && env_phase != ENV_RELEASE) begin
                  env_phase <= ENV_RELEASE;
                  env_count <= '0;
                end
              end
              FUNC_CC: begin
                glide_coeff <= head.coeff;
                cc_seen     <= 1'b1;
              end
              default: begin
                mix        <= head.mix;
                res_sample <= head.mix;
                res_env    <= ENV_IDLE;
              end
            endcase
          end
        end
        ST_ATT_DIV: div_num <= prod[31:0];
        ST_ATT_FIX: begin
          if (count_inc >= 16'(ATTACK_SAMPLES)) begin
            gain      <= target_peak;
            env_phase <= ENV_DECAY;
            env_count <= '0;
          end else begin
            gain      <= att_q[15:0];
            env_count <= count_inc;
          end
        end
        ST_DEC_DIV: div_num <= prod[47:16];
        ST_DEC_FIX: begin
          gain      <= target_peak - dec_q[15:0];
          env_count <= count_inc;
          if (count_inc >= 16'(DECAY_SAMPLES)) begin
            env_phase <= ENV_SUSTAIN;
          end
        end
        ST_GAIN_LOAD: gain <= prod[31:16];
        ST_REL: begin
          gain <= prod[31:16];
          if (prod[31:16] < GAIN_FLOOR) begin
            env_phase <= ENV_IDLE;
          end
        end
        ST_GLIDE: phase_acc <= phase_acc + current_inc;
        ST_WAVE: begin
          current_inc <= glide_up ? (target_inc + prod[47:16]) : (target_inc - prod[47:16]);
          wave_mag    <= wave_mag_next;
          wave_neg    <= wave_neg_next;
        end
        ST_MIX: begin
          res_sample <= mix_sat;
          res_env    <= env_phase;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && emit_ok) begin
      m_axis_tdata <= {5'd0, res_env, res_sample};
    end
  end

endmodule

`default_nettype wire

@@ sv/mono_synth_voice_top.sv @@
// ----------------------------------------------------------------------------
// Mono synth voice top level
// Monophonic voice with ADSR-style envelope, portamento and three wave shapes.
// ----------------------------------------------------------------------------
// Note on, note off and controller words are handled in the fetch state and
// give no output word; a controller other than 74 is dropped at the input.
// A sample tick gives one output word: fetch and emit while idle; fetch,
// release and emit when release ends the voice; else fetch, the attack divide
// and fix, the decay scale, divide and fix (plus a gain load on the tick that
// enters sustain) or the release step, none in sustain, then glide, wave,
// voice, norm, mix and emit, which waits until the previous output word is
// taken. One 33x33 multiplier does every product, one product per cycle. A
// command queue of QUEUE_DEPTH words between decoder and back end keeps input
// flowing while a tick runs or waits, until full. Configuration writes take
// effect at once (glide init only before a CC 74) and are meant for idle time.
`default_nettype none
`include "mono_synth_voice_top_assert.svh"

module mono_synth_voice_top import msv_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = MSV_QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [15:0]            cfg_data,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // note[6:0], velocity[13:7], cc_number[20:14], cc_value[27:21],
  // mix_in[43:28], zero fill
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]             s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // sample_out[15:0], env_state[18:16], zero fill
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  cmd_t    push_cmd;
  cmd_t    head;

  msv_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_stat        (q_stat),
    .push          (q_push),
    .push_cmd      (push_cmd)
  );

  msv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  msv_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_stat        (q_stat),
    .head          (head),
    .pop           (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  `MSV_ASSERT_SAME(a_no_push_full, q_push, !q_stat.full)
  `MSV_ASSERT_SAME(a_no_pop_empty, q_pop, !q_stat.empty)
  `MSV_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_stat.empty)

endmodule

`default_nettype wire

@@ bench/tb_mono_synth_voice_top.sv @@
// ----------------------------------------------------------------------------
// Mono synth voice testbench
// Streams note, controller and tick words into the voice under bursty input
// and a stalling output, predicts every tick result in-bench and compares
// sample and envelope phase word by word across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_mono_synth_voice_top;
  import msv_pkg::*;

  typedef struct packed {
    func_t       kind;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [6:0]  ccn;
    logic [6:0]  ccv;
    logic [15:0] mix;
  } voice_word_t;

  typedef struct packed {
    logic [15:0] sample;
    logic [2:0]  phase;
  } tick_out_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = '0;
  logic [15:0]            cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  mono_synth_voice_top DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #10 clk = ~clk;

  // voice model: registers and state
  logic [1:0]  wave_sel = WAVE_RESET;
  logic [15:0] sustain = SUSTAIN_RESET;
  logic [15:0] rel_mult = RELEASE_RESET;
  env_phase_t  env = ENV_IDLE;
  logic [15:0] env_cnt = '0;
  logic [15:0] gain = '0;
  logic [15:0] peak = '0;
  logic [31:0] phase_acc = '0;
  logic [31:0] cur_inc = '0;
  logic [31:0] tgt_inc = '0;
  logic [15:0] glide_k = GLIDE_INIT_RESET;
  bit          cc_seen = 1'b0;

  voice_word_t pending[$];
  tick_out_t   tick_results[$];
  voice_word_t cur_word;
  int          errors = 0;
  int          n_words = 0, n_ticks = 0, n_results = 0, n_notes = 0, n_phases = 0;
  int          burst_left = 0, gap_left = 0, hold_left = 0, mode_left = 0;
  int          rx_mode = 0;
  bit          start_hold = 1'b0;
  bit          nv;

  function automatic logic [31:0] pitch_inc(logic [6:0] n);
    int unsigned oct, k;
    logic [63:0] den, v;
    oct = n / 12;
    k   = n % 12;
    den = 64'(SAMPLE_RATE) << (10 - oct);
    v   = ((64'(TOP_OCTAVE[k]) << 16) + (den >> 1)) / den;
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [63:0] sqrt_floor(logic [63:0] a);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] velocity_peak(logic [6:0] v);
    logic [63:0] c, s, p;
    c = 64'(v) * 64'(v) * 64'(v);
    s = sqrt_floor((c << 32) / 64'(127 * 127 * 127));
    p = (s * 64'd45875 + 64'd32768) >> 16;
    return p[15:0];
  endfunction

  function automatic logic [15:0] glide_from_cc(logic [6:0] v);
    logic [63:0] den, x, x2, x3, e, q;
    den = 64'(SAMPLE_RATE) * (64'd635 + 64'd395 * 64'(v));
    x   = (64'd127000 << 32) / den;
    x2  = (x * x) >> 32;
    x3  = (x2 * x) >> 32;
    e   = (64'd1 << 32) - x + (x2 >> 1) - x3 / 64'd6;
    q   = (e + 64'd32768) >> 16;
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic longint sine_of(logic [31:0] ph);
    logic [63:0] a, x, th, t2, r, s;
    a = 64'(ph >> (32 - SINE_BITS)) << (32 - SINE_BITS);
    x = a[30] ? (64'h4000_0000 - 64'(a[29:0])) : 64'(a[29:0]);
    th = (x * TWO_PI_Q28) >> 30;
    t2 = (th * th) >> 30;
    r  = 64'd1 << 30;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 64'd110;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 64'd72;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 64'd42;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 64'd20;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 64'd6;
    s  = (((th * r) >> 30) + 64'd16384) >> 15;
    return a[31] ? -longint'(s) : longint'(s);
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      CFG_WAVEFORM: wave_sel = val[1:0];
      CFG_GLIDE_INIT: begin
        if (!cc_seen) glide_k = val;
      end
      CFG_SUSTAIN: sustain = val;
      default: rel_mult = val;
    endcase
  endfunction

  // advance the voice by one accepted word, queue a result for ticks
  function automatic void voice_step(voice_word_t w);
    logic [63:0] drop, d;
    longint      wave, norm, prod, mag, sum;
    tick_out_t   res;
    bit          ended;
    ended = 0;
    case (w.kind)
      FUNC_NOTE_ON: begin
        tgt_inc = pitch_inc(w.note);
        if (env == ENV_IDLE) begin
          cur_inc   = tgt_inc;
          phase_acc = '0;
        end
        if (env == ENV_IDLE || env == ENV_RELEASE) begin
          env = ENV_ATTACK;
          env_cnt = '0;
          peak = velocity_peak(w.vel);
          gain = '0;
        end
      end
      FUNC_NOTE_OFF: begin
        if (env != ENV_IDLE && env != ENV_RELEASE) begin
          env = ENV_RELEASE;
          env_cnt = '0;
        end
      end
      FUNC_CC: begin
        if (w.ccn == CC_GLIDE) begin
          glide_k = glide_from_cc(w.ccv);
          cc_seen = 1'b1;
        end
      end
      default: begin
        res.sample = w.mix;
        res.phase  = ENV_IDLE;
        if (env != ENV_IDLE) begin
          case (env)
            ENV_ATTACK: begin
              gain = 16'((64'(env_cnt) * 64'(peak)) / ATTACK_SAMPLES);
              env_cnt = env_cnt + 1'b1;
              if (env_cnt >= ATTACK_SAMPLES) begin
                gain = peak;
                env = ENV_DECAY;
                env_cnt = '0;
              end
            end
            ENV_DECAY: begin
              drop = 64'(peak) * 64'(env_cnt) * (64'd65536 - 64'(sustain))
                     / (64'(DECAY_SAMPLES) * 64'd65536);
              gain = peak - drop[15:0];
              env_cnt = env_cnt + 1'b1;
              if (env_cnt >= DECAY_SAMPLES) begin
                gain = 16'((64'(peak) * 64'(sustain)) >> 16);
                env = ENV_SUSTAIN;
              end
            end
            ENV_RELEASE: begin
              gain = 16'((64'(gain) * 64'(rel_mult)) >> 16);
              if (gain < GAIN_FLOOR) begin
                env = ENV_IDLE;
                ended = 1;
              end
            end
            default: ;
          endcase
          if (!ended) begin
            phase_acc = phase_acc + cur_inc;
            if (cur_inc >= tgt_inc) begin
              d = 64'(cur_inc - tgt_inc);
              cur_inc = tgt_inc + 32'((d * 64'(glide_k)) >> 16);
            end else begin
              d = 64'(tgt_inc - cur_inc);
              cur_inc = tgt_inc - 32'((d * 64'(glide_k)) >> 16);
            end
            if (wave_sel == WAVE_SAW) begin
              wave = longint'(phase_acc >> 16) - 32768;
              norm = NORM_SAW;
            end else if (wave_sel == WAVE_SQUARE) begin
              wave = phase_acc[31] ? -32768 : 32768;
              norm = NORM_SQUARE;
            end else begin
              wave = sine_of(phase_acc);
              norm = NORM_SINE;
            end
            prod = longint'(gain) * wave * norm;
            mag  = (prod < 0) ? -prod : prod;
            mag  = (mag + (64'sd1 <<< 29)) / (64'sd1 <<< 30);
            sum  = longint'($signed(w.mix)) + ((prod < 0) ? -mag : mag);
            if (sum > 32767) sum = 32767;
            if (sum < -32768) sum = -32768;
            res.sample = 16'(sum);
            res.phase  = env;
          end
        end
        tick_results.push_back(res);
      end
    endcase
  endfunction

  function automatic voice_word_t mk_word(func_t k, int note, int vel, int mix);
    voice_word_t w;
    w.kind = k;
    w.note = 7'(note);
    w.vel  = 7'(vel);
    w.ccn  = 7'($urandom);
    w.ccv  = 7'($urandom);
    w.mix  = 16'(mix);
    return w;
  endfunction

  function automatic voice_word_t rand_word();
    voice_word_t w;
    int          r;
    w = mk_word(FUNC_TICK, $urandom, $urandom, $urandom);
    r = $urandom_range(0, 99);
    if (r < 6) w.kind = FUNC_NOTE_ON;
    else if (r < 10) w.kind = FUNC_NOTE_OFF;
    else if (r < 15) begin
      w.kind = FUNC_CC;
      if (r < 13) w.ccn = CC_GLIDE;
    end
    return w;
  endfunction

  // input driver: bursts with random gaps, hold the word until taken
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        voice_step(cur_word);
        n_words++;
        if (cur_word.kind == FUNC_TICK) n_ticks++;
        if (cur_word.kind == FUNC_NOTE_ON) n_notes++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          cur_word = pending.pop_front();
          s_axis_tuser <= cur_word.kind;
          s_axis_tdata <= IN_TDATA_W'({cur_word.mix, cur_word.ccv, cur_word.ccn,
                                       cur_word.vel, cur_word.note});
          nv = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        s_axis_tvalid <= nv;
      end
    end
  end

  // output ready: long hold-off on request, else a changing stall pattern
  always @(posedge clk) begin
    if (start_hold) begin
      start_hold = 1'b0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(1, 64);
      end
      mode_left--;
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // compare each output word with the oldest predicted tick result
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (tick_results.size() == 0) begin
        if (errors < 10) $display("unexpected output word %h", m_axis_tdata);
        errors++;
      end else begin
        if (m_axis_tdata[15:0] !== tick_results[0].sample ||
            m_axis_tdata[18:16] !== tick_results[0].phase) begin
          if (errors < 10)
            $display("tick %0d: expected sample %h env %0d, got sample %h env %0d",
                     n_results, tick_results[0].sample, tick_results[0].phase,
                     m_axis_tdata[15:0], m_axis_tdata[18:16]);
          errors++;
        end
        void'(tick_results.pop_front());
      end
    end
  end

  task automatic drain();
    while (pending.size() > 0 || s_axis_tvalid || tick_results.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(int wf, int gi, int sus, int rel);
    drain();
    write_reg(CFG_WAVEFORM, 16'(wf));
    write_reg(CFG_GLIDE_INIT, 16'(gi));
    write_reg(CFG_SUSTAIN, 16'(sus));
    write_reg(CFG_RELEASE, 16'(rel));
    n_phases++;
  endtask

  task automatic push_random(int n);
    repeat (n) pending.push_back(rand_word());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // glide init written before any controller 74 takes effect at once
    set_regs(0, 40000, 45875, 30000);
    pending.push_back(mk_word(FUNC_TICK, 0, 0, 32767));
    pending.push_back(mk_word(FUNC_TICK, 0, 0, -32768));
    pending.push_back(mk_word(FUNC_NOTE_OFF, 0, 0, 0));
    pending.push_back(mk_word(FUNC_NOTE_ON, 127, 127, 0));
    pending.push_back(mk_word(FUNC_TICK, 0, 0, 32767));
    pending.push_back(mk_word(FUNC_TICK, 0, 0, -32768));
    pending.push_back(mk_word(FUNC_NOTE_ON, 0, 0, 0));
    pending.push_back(mk_word(FUNC_TICK, 0, 0, 0));
    pending.push_back(mk_word(FUNC_CC, 0, 0, 0));
    pending[$].ccn = 7'd73;
    pending.push_back(mk_word(FUNC_CC, 0, 0, 0));
    pending[$].ccn = CC_GLIDE;
    pending[$].ccv = 7'd127;
    pending.push_back(mk_word(FUNC_TICK, 0, 0, 12345));
    pending.push_back(mk_word(FUNC_NOTE_OFF, 0, 0, 0));
    pending.push_back(mk_word(FUNC_TICK, 0, 0, 0));
    pending.push_back(mk_word(FUNC_NOTE_ON, 60, 0, 0));
    pending.push_back(mk_word(FUNC_TICK, 0, 0, -100));
    pending.push_back(mk_word(FUNC_NOTE_OFF, 0, 0, 0));
    pending.push_back(mk_word(FUNC_TICK, 0, 0, 100));
    pending.push_back(mk_word(FUNC_TICK, 0, 0, 0));
    pending.push_back(mk_word(FUNC_CC, 0, 0, 0));
    pending[$].ccn = CC_GLIDE;
    pending[$].ccv = 7'd0;
    pending.push_back(mk_word(FUNC_NOTE_ON, 69, 64, 0));
    pending.push_back(mk_word(FUNC_TICK, 0, 0, 0));

    // long envelope: attack into decay, then release to idle
    set_regs(3, 65535, 30000, 0);
    pending.push_back(mk_word(FUNC_NOTE_ON, 45, 100, 0));
    repeat (600) pending.push_back(mk_word(FUNC_TICK, 0, 0, $urandom));
    pending.push_back(mk_word(FUNC_NOTE_ON, 80, 90, 0));
    push_random(20);
    pending.push_back(mk_word(FUNC_NOTE_OFF, 0, 0, 0));
    pending.push_back(mk_word(FUNC_TICK, 0, 0, 0));
    pending.push_back(mk_word(FUNC_TICK, 0, 0, 0));

    set_regs(1, 0, 0, 20000);
    push_random(200);
    start_hold = 1'b1;
    push_random(200);

    set_regs(2, 0, 65535, 60000);
    push_random(150);
    drain();
    push_random(150);

    set_regs(0, 12000, $urandom, 65535);
    push_random(150);

    set_regs(1, $urandom, $urandom, 40000);
    push_random(150);

    drain();
    $display("%0d words in, %0d ticks, %0d note-ons, %0d output words, %0d settings",
             n_words, n_ticks, n_notes, n_results, n_phases);
    if (errors == 0 && tick_results.size() == 0) begin
      $display("mono_synth_voice_top: match");
    end else begin
      $display("%0d mismatches", errors);
      $display("mono_synth_voice_top: mismatch");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", tick_results.size());
    $display("mono_synth_voice_top: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/msv_pkg.sv
sv/msv_front.sv
sv/msv_queue.sv
sv/msv_back.sv
sv/mono_synth_voice_top.sv
bench/tb_mono_synth_voice_top.sv
